[hdl/mcd_pkg.sv]
// shared types, codes and constants of the multicore dispatcher
`timescale 1ns / 1ps

package mcd_pkg;

  localparam int PROCESS_SLOTS_DEF = 64;
  localparam int CORE_COUNT_DEF    = 4;
  localparam int DATA_W            = 16;
  localparam int STATUS_W          = 4;
  localparam int SLOT_OUT_W        = 6;
  localparam int CORE_IN_W         = 2;
  localparam int INUSE_W           = 3;
  localparam int CORES_CFG_W       = 3;
  localparam int REG_INDEX_W       = 2;

  localparam logic [DATA_W-1:0]      QUANTUM_RESET = 16'd5;
  localparam logic [CORES_CFG_W-1:0] CORES_RESET   = 3'd4;

  typedef enum logic [1:0] {
    ACT_ADD      = 2'd0,
    ACT_DISPATCH = 2'd1,
    ACT_EXECUTE  = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED      = 4'd0,
    ST_FULL       = 4'd1,
    ST_DISPATCHED = 4'd2,
    ST_NONE_READY = 4'd3,
    ST_CORE_BUSY  = 4'd4,
    ST_CORE_IDLE  = 4'd5,
    ST_RAN        = 4'd6,
    ST_EXPIRED    = 4'd7,
    ST_FINISHED   = 4'd8,
    ST_BAD_CORE   = 4'd9
  } status_t;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_MODE    = 2'd0,
    REG_QUANTUM = 2'd1,
    REG_CORES   = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [DATA_W-1:0] total;
    logic [DATA_W-1:0] done;
    logic              finished;
    logic              assigned;
  } entry_t;

  typedef struct packed {
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] wrap;
    logic              ge;
  } alu_res_t;

endpackage

[hdl/multicore_rr_fcfs_dispatcher.sv]
// top level: process table dispatcher with round robin and fcfs scheduling
//
//  channel   ports                                    transaction when
//  command   start busy action core instruction_count start && !busy
//  result    valid status slot completed active_cores  valid (one cycle, no stall)
//            all_done
//  config    wr_en wr_index wr_data                   wr_en
//
// add, bad core and execute on an idle core: result in the cycle after start
// execute and dispatch to a busy core: one table ram read, then the result from S_UPDATE
// dispatch scan: one slot per cycle through the table ram, at most process count slots
// busy rises the cycle after a scan or busy-core start, low again in the result cycle
// rst is synchronous; the process table needs no clearing pass
`timescale 1ns / 1ps

module multicore_rr_fcfs_dispatcher import mcd_pkg::*; #(
  parameter int PROCESS_SLOTS = PROCESS_SLOTS_DEF,
  parameter int CORE_COUNT    = CORE_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             action,
  input  logic [CORE_IN_W-1:0]   core,
  input  logic [DATA_W-1:0]      instruction_count,
  output logic                   valid,
  output logic [STATUS_W-1:0]    status,
  output logic [SLOT_OUT_W-1:0]  slot,
  output logic [DATA_W-1:0]      completed,
  output logic [INUSE_W-1:0]     active_cores,
  output logic                   all_done,
  input  logic                   wr_en,
  input  logic [REG_INDEX_W-1:0] wr_index,
  input  logic [DATA_W-1:0]      wr_data
);

  localparam int SW  = $clog2(PROCESS_SLOTS);
  localparam int PW  = SW + 1;
  localparam int CIW = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;
  localparam int CNW = $clog2(CORE_COUNT + 1);
  localparam logic [PW-1:0] SLOTS_P = PW'(PROCESS_SLOTS);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_GRANT  = 4'b0100,
    S_UPDATE = 4'b1000
  } state_t;

  state_t state;

  logic                   round_robin_mode;
  logic [DATA_W-1:0]      quantum;
  logic [CORES_CFG_W-1:0] cores_enabled;

  logic [SW-1:0]         core_slot [CORE_COUNT];
  logic [CORE_COUNT-1:0] core_busy;
  logic [DATA_W-1:0]     slice_left [CORE_COUNT];
  logic [PW-1:0]         process_total;
  logic [SW-1:0]         rr_pointer;
  logic [PW-1:0]         fcfs_pointer;
  logic [PW-1:0]         finished_total;

  action_t        cur_action;
  logic [CIW-1:0] cur_core;
  logic [SW-1:0]  iss_idx;
  logic           iss_more;
  logic [SW-1:0]  chk_idx;
  logic           chk_valid;
  logic           chk_last;
  entry_t         ent;

  logic                     ram_we;
  logic [SW-1:0]            ram_waddr;
  entry_t                   ram_wdata;
  logic [SW-1:0]            ram_raddr;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t                   rd_ent;

  logic [DATA_W-1:0] alu_a;
  logic [DATA_W-1:0] alu_b;
  alu_res_t          alu;

  logic              core_ok;
  logic [CIW-1:0]    in_core;
  logic              table_full;
  logic              scan_ready;
  logic              issue_last;
  logic              adv;
  logic [DATA_W-1:0] new_done;
  logic              fin;
  logic [DATA_W-1:0] slice_cur;
  logic [DATA_W-1:0] slice_new;
  logic              expired;
  logic [DATA_W-1:0] quantum_eff;
  logic [CNW-1:0]    busy_cnt;

  mcd_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (PROCESS_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mcd_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu)
  );

  assign busy       = (state != S_IDLE);
  assign in_core    = CIW'(core);
  assign core_ok    = (32'(core) < 32'(cores_enabled)) && (32'(core) < CORE_COUNT);
  assign table_full = (process_total >= SLOTS_P);
  assign rd_ent     = entry_t'(ram_rdata);
  assign scan_ready = chk_valid && !rd_ent.finished && !rd_ent.assigned;
  assign issue_last = round_robin_mode ? (SW'(alu.wrap) == rr_pointer) : alu.ge;
  assign quantum_eff = (quantum == '0) ? DATA_W'(1) : quantum;

  always_comb begin
    unique case (state)
      S_UPDATE: begin
        alu_a = rd_ent.done;
        alu_b = rd_ent.total;
      end
      S_GRANT: begin
        alu_a = DATA_W'(chk_idx);
        alu_b = DATA_W'(process_total);
      end
      default: begin
        alu_a = DATA_W'(iss_idx);
        alu_b = DATA_W'(process_total);
      end
    endcase
  end

  // execute step
  always_comb begin
    adv       = (rd_ent.done != rd_ent.total);
    new_done  = adv ? alu.sum : rd_ent.done;
    fin       = !adv || alu.ge;
    slice_cur = slice_left[cur_core];
    slice_new = (round_robin_mode && adv && (slice_cur != '0)) ? slice_cur - DATA_W'(1)
                                                              : slice_cur;
    expired   = round_robin_mode && (slice_new == '0);
  end

  always_comb begin
    busy_cnt = '0;
    for (int i = 0; i < CORE_COUNT; i++) begin
      busy_cnt = busy_cnt + CNW'(core_busy[i]);
    end
  end

  assign active_cores = INUSE_W'(busy_cnt);
  assign all_done     = (finished_total == process_total);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    if (state == S_SCAN) begin
      ram_raddr = iss_idx;
    end else begin
      ram_raddr = core_ok ? core_slot[in_core] : '0;
    end
    unique case (state)
      S_IDLE: begin
        if (start && (action == ACT_ADD) && !table_full) begin
          ram_we    = 1'b1;
          ram_waddr = SW'(process_total);
          ram_wdata = '{total: instruction_count, done: '0, finished: 1'b0, assigned: 1'b0};
        end
      end
      S_GRANT: begin
        ram_we    = 1'b1;
        ram_waddr = chk_idx;
        ram_wdata = '{total: ent.total, done: ent.done, finished: 1'b0, assigned: 1'b1};
      end
      S_UPDATE: begin
        if (cur_action == ACT_EXECUTE) begin
          ram_we    = 1'b1;
          ram_waddr = core_slot[cur_core];
          ram_wdata = '{total: rd_ent.total, done: new_done, finished: fin,
                        assigned: !fin && !expired};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      valid            <= 1'b0;
      round_robin_mode <= 1'b0;
      quantum          <= QUANTUM_RESET;
      cores_enabled    <= CORES_RESET;
      core_busy        <= '0;
      for (int i = 0; i < CORE_COUNT; i++) begin
        core_slot[i]  <= '0;
        slice_left[i] <= '0;
      end
      process_total  <= '0;
      rr_pointer     <= '0;
      fcfs_pointer   <= '0;
      finished_total <= '0;
      iss_more       <= 1'b0;
      chk_valid      <= 1'b0;
      chk_last       <= 1'b0;
    end else begin
      valid <= 1'b0;

      if (wr_en) begin
        unique case (wr_index)
          REG_MODE:    round_robin_mode <= wr_data[0];
          REG_QUANTUM: quantum          <= wr_data;
          REG_CORES:   cores_enabled    <= wr_data[CORES_CFG_W-1:0];
          default: begin
          end
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            cur_action <= action_t'(action);
            cur_core   <= in_core;
            unique case (action)
              ACT_ADD: begin
                valid     <= 1'b1;
                completed <= '0;
                if (table_full) begin
                  status <= ST_FULL;
                  slot   <= '0;
                end else begin
                  status        <= ST_ADDED;
                  slot          <= SLOT_OUT_W'(process_total[SW-1:0]);
                  process_total <= process_total + PW'(1);
                end
              end
              ACT_DISPATCH, ACT_EXECUTE: begin
                if (!core_ok) begin
                  valid     <= 1'b1;
                  status    <= ST_BAD_CORE;
                  slot      <= '0;
                  completed <= '0;
                end else if (core_busy[in_core]) begin
                  state <= S_UPDATE;
                end else if (action == ACT_EXECUTE) begin
                  valid     <= 1'b1;
                  status    <= ST_CORE_IDLE;
                  slot      <= '0;
                  completed <= '0;
                end else if (round_robin_mode ? (process_total == '0)
                                              : (fcfs_pointer >= process_total)) begin
                  valid     <= 1'b1;
                  status    <= ST_NONE_READY;
                  slot      <= '0;
                  completed <= '0;
                end else begin
                  iss_idx   <= round_robin_mode ? rr_pointer : SW'(fcfs_pointer);
                  iss_more  <= 1'b1;
                  chk_valid <= 1'b0;
                  state     <= S_SCAN;
                end
              end
              default: begin
              end
            endcase
          end
        end

        S_SCAN: begin
          if (scan_ready) begin
            ent   <= rd_ent;
            state <= S_GRANT;
          end else if (chk_valid && chk_last) begin
            valid     <= 1'b1;
            status    <= ST_NONE_READY;
            slot      <= '0;
            completed <= '0;
            state     <= S_IDLE;
          end else begin
            chk_valid <= iss_more;
            chk_idx   <= iss_idx;
            chk_last  <= issue_last;
            if (iss_more) begin
              iss_idx  <= SW'(alu.wrap);
              iss_more <= !issue_last;
            end
          end
        end

        S_GRANT: begin
          core_busy[cur_core]  <= 1'b1;
          core_slot[cur_core]  <= chk_idx;
          slice_left[cur_core] <= quantum_eff;
          if (round_robin_mode) begin
            rr_pointer <= SW'(alu.wrap);
          end else begin
            fcfs_pointer <= PW'(alu.sum);
          end
          valid     <= 1'b1;
          status    <= ST_DISPATCHED;
          slot      <= SLOT_OUT_W'(chk_idx);
          completed <= ent.done;
          state     <= S_IDLE;
        end

        S_UPDATE: begin
          valid <= 1'b1;
          slot  <= SLOT_OUT_W'(core_slot[cur_core]);
          if (cur_action == ACT_DISPATCH) begin
            status    <= ST_CORE_BUSY;
            completed <= rd_ent.done;
          end else begin
            completed            <= new_done;
            slice_left[cur_core] <= slice_new;
            if (fin) begin
              status              <= ST_FINISHED;
              core_busy[cur_core] <= 1'b0;
              finished_total      <= finished_total + PW'(1);
            end else if (expired) begin
              status              <= ST_EXPIRED;
              core_busy[cur_core] <= 1'b0;
            end else begin
              status <= ST_RAN;
            end
          end
          state <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_result_ends_work: assert property (@(posedge clk) disable iff (rst)
    valid |-> !busy)
    else $error("result strobe while the sequencer is still working");

  a_add_answers_next: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (action == ACT_ADD)) |=> (valid && !busy))
    else $error("add transaction did not answer in the next cycle");

  a_unused_action_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (action == 2'd3)) |=> (!valid && !busy))
    else $error("unused action code produced a result");

  a_finished_bounded: assert property (@(posedge clk) disable iff (rst)
    finished_total <= process_total)
    else $error("more finished processes than added processes");
`endif

endmodule

[hdl/mcd_ram.sv]
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module mcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/mcd_alu.sv]
// shared increment and compare unit for scan index, pointers and instruction count
`timescale 1ns / 1ps

module mcd_alu import mcd_pkg::*; (
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  output alu_res_t          res
);

  logic [DATA_W:0] inc;

  always_comb begin
    inc      = {1'b0, a} + (DATA_W+1)'(1);
    res.sum  = inc[DATA_W-1:0];
    res.ge   = inc >= {1'b0, b};
    res.wrap = res.ge ? '0 : inc[DATA_W-1:0];
  end

endmodule
